// ----- design/cct_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cct_pkg: shared types and functions of the character class tokenizer
// Holds the byte class table, token and error codes, and the position helpers.
// ----------------------------------------------------------------------------
package cct_pkg;

  // Width of the byte position counter and of the token offset fields.
  localparam int unsigned POS_BITS = 32;
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_BITS = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_BITS = $clog2(RES_DEPTH + 1);

  typedef logic [POS_BITS-1:0] pos_t;

  localparam pos_t POS_MAX = {POS_BITS{1'b1}};

  typedef enum logic [2:0] {
    KIND_UNDEF = 3'd0,
    KIND_SEP   = 3'd1,
    KIND_OPER  = 3'd2,
    KIND_NUM   = 3'd3,
    KIND_ID    = 3'd4,
    KIND_STR   = 3'd5,
    KIND_CHR   = 3'd6
  } token_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_STR  = 2'd1,
    ERR_CHR  = 2'd2
  } error_kind_e;

  // Characters with a special role in the scanner.
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // One result item as it waits in the result queue.
  typedef struct packed {
    token_kind_e kind;
    pos_t        start;
    pos_t        length;
    error_kind_e err;
    logic        last;
  } result_t;

  // Byte class table.
  function automatic token_kind_e classify(input logic [7:0] b);
    token_kind_e cls;
    case (b)
      8'h20, 8'h09, 8'h0D, 8'h0A, 8'h0B, 8'h0C: cls = KIND_SEP;
      8'h00, 8'h40, 8'h24, 8'h60, 8'h23, 8'h7B, 8'h7D, 8'h2C, 8'h7C,
      8'h5B, 8'h5D, 8'h2B, 8'h2D, 8'h25, 8'h3B, 8'h3A, 8'h3F, 8'h3C,
      8'h3E, 8'h3D, 8'h21, 8'h26, 8'h7E, 8'h5E, 8'h2A, 8'h5C, 8'h28,
      8'h29, 8'h2F, 8'h2E: cls = KIND_OPER;
      8'h22: cls = KIND_STR;
      8'h27: cls = KIND_CHR;
      default: begin
        if (b >= 8'h30 && b <= 8'h39) begin
          cls = KIND_NUM;
        end else if (b == 8'h5F || (b >= 8'h41 && b <= 8'h5A) ||
                     (b >= 8'h61 && b <= 8'h7A)) begin
          cls = KIND_ID;
        end else begin
          cls = KIND_UNDEF;
        end
      end
    endcase
    return cls;
  endfunction

  // Increment that holds at the top of the counter range.
  function automatic pos_t sat_inc(input pos_t x);
    return (x == POS_MAX) ? x : x + pos_t'(1);
  endfunction

  // Token length from start up to pos, with the byte at pos when incl is set.
  function automatic pos_t span(input pos_t start, input pos_t pos, input logic incl);
    pos_t d;
    d = (pos >= start) ? pos - start : '0;
    if (incl) begin
      d = sat_inc(d);
    end
    return (d == '0) ? pos_t'(1) : d;
  endfunction

  // Error code of a literal that ends before its closing quote.
  function automatic error_kind_e lit_err(input token_kind_e k);
    error_kind_e e;
    case (k)
      KIND_STR: e = ERR_STR;
      KIND_CHR: e = ERR_CHR;
      default:  e = ERR_NONE;
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

// ----- design/cct_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cct_if: byte and token channels of the character class tokenizer
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface cct_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_text;

  modport source (output valid, output byte_value, output end_of_text, input ready);
  modport sink   (input valid, input byte_value, input end_of_text, output ready);
endinterface

interface cct_token_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [31:0] token_start;
  logic [31:0] token_length;
  logic [1:0]  error_kind;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output error_kind, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input error_kind, input last_of_run,
                  output ready);
endinterface
`default_nettype wire

// ----- design/char_class_tokenizer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// char_class_tokenizer: byte stream to token stream
// Classifies each byte, tracks the open token and queues finished tokens.
// ----------------------------------------------------------------------------
//   Channel  Dir  Item                 Fields
//   in_i     in   one source byte      byte_value, end_of_text
//   out_o    out  one finished token   token_kind, token_start, token_length,
//                                      error_kind, last_of_run
//
// A byte is taken in every cycle while the four-entry result queue has room
// for two tokens; its tokens enter the queue at the same edge.
// The queue drains one token per cycle while out_o is ready; the input keeps
// flowing while output stalls until the queue holds more than two tokens.
// Reset clears the open token, the byte position and the queue at once.
// ----------------------------------------------------------------------------
module char_class_tokenizer
  import cct_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  cct_byte_if.sink     in_i,
  cct_token_if.source  out_o
);

  // Scanner state.
  logic        open_q, open_d;
  token_kind_e kind_q, kind_d;
  pos_t        start_q, start_d;
  pos_t        pos_q, pos_d;

  // Result queue.
  result_t                 fifo_q [RES_DEPTH];
  logic [RES_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [RES_CNT_BITS-1:0] count_q;

  logic        in_fire, out_fire;
  token_kind_e cls;
  logic        consumed;
  logic        e0_valid, e1_valid;
  result_t     e0, e1;
  result_t     slot0, slot1;
  logic [1:0]  n_push;

  assign in_i.ready = (count_q <= RES_CNT_BITS'(RES_DEPTH - 2));
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;
  assign cls        = classify(in_i.byte_value);

  // Token decisions for the byte at the input.
  always_comb begin
    logic        still_open;
    logic [7:0]  quote;
    consumed   = 1'b0;
    e0_valid   = 1'b0;
    e1_valid   = 1'b0;
    e0         = '0;
    e1         = '0;
    still_open = open_q;
    kind_d     = kind_q;
    start_d    = start_q;
    quote      = (kind_q == KIND_STR) ? CH_DQUOTE : CH_SQUOTE;

    if (open_q) begin
      case (kind_q)
        KIND_STR, KIND_CHR: begin
          if (in_i.byte_value == quote) begin
            consumed   = 1'b1;
            e0_valid   = 1'b1;
            e0         = '{kind_q, start_q, span(start_q, pos_q, 1'b1), ERR_NONE, 1'b0};
            still_open = 1'b0;
          end else if (in_i.byte_value == CH_NEWLINE) begin
            e0_valid   = 1'b1;
            e0         = '{kind_q, start_q, span(start_q, pos_q, 1'b0),
                           lit_err(kind_q), 1'b0};
            still_open = 1'b0;
          end else begin
            consumed = 1'b1;
          end
        end
        KIND_UNDEF, KIND_SEP: consumed = (cls == kind_q);
        KIND_NUM, KIND_ID:    consumed = (cls == KIND_NUM) || (cls == KIND_ID);
        default:              consumed = 1'b0;
      endcase

      // Close the open token when this byte does not extend it or ends the text.
      if (still_open) begin
        if (consumed) begin
          if (in_i.end_of_text) begin
            e0_valid   = 1'b1;
            e0         = '{kind_q, start_q, span(start_q, pos_q, 1'b1),
                           lit_err(kind_q), 1'b0};
            still_open = 1'b0;
          end
        end else begin
          e0_valid   = 1'b1;
          e0         = '{kind_q, start_q, span(start_q, pos_q, 1'b0), ERR_NONE, 1'b0};
          still_open = 1'b0;
        end
      end
    end

    // A byte not taken by the open token starts a token of its own.
    if (!consumed) begin
      if (cls == KIND_OPER) begin
        e1_valid = 1'b1;
        e1       = '{KIND_OPER, pos_q, pos_t'(1), ERR_NONE, 1'b0};
      end else if (in_i.end_of_text) begin
        e1_valid = 1'b1;
        e1       = '{cls, pos_q, pos_t'(1), lit_err(cls), 1'b0};
      end else begin
        still_open = 1'b1;
        kind_d     = cls;
        start_d    = pos_q;
      end
    end

    // The end of the text returns the scanner state to the reset values.
    if (in_i.end_of_text) begin
      open_d  = 1'b0;
      kind_d  = KIND_UNDEF;
      start_d = '0;
      pos_d   = '0;
    end else begin
      open_d  = still_open;
      pos_d   = sat_inc(pos_q);
    end
  end

  // Pack the tokens of this byte in order and mark the last one.
  always_comb begin
    slot0 = e0_valid ? e0 : e1;
    slot1 = e1;
    n_push = 2'(e0_valid) + 2'(e1_valid);
    if (n_push == 2'd2) begin
      slot1.last = 1'b1;
    end else begin
      slot0.last = 1'b1;
    end
  end

  // Scanner state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      kind_q  <= KIND_UNDEF;
      start_q <= '0;
      pos_q   <= '0;
    end else if (in_fire) begin
      open_q  <= open_d;
      kind_q  <= kind_d;
      start_q <= start_d;
      pos_q   <= pos_d;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= wr_ptr_q + RES_PTR_BITS'(n_push);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + RES_PTR_BITS'(1);
      end
      count_q <= count_q + RES_CNT_BITS'(in_fire ? n_push : 2'd0)
                 - RES_CNT_BITS'(out_fire);
    end
  end

  // Queue entries.
  always_ff @(posedge clk_i) begin
    if (in_fire && n_push != 2'd0) begin
      fifo_q[wr_ptr_q] <= slot0;
      if (n_push == 2'd2) begin
        fifo_q[wr_ptr_q + RES_PTR_BITS'(1)] <= slot1;
      end
    end
  end

  // Output side reads the head of the queue; offsets are carried as 32 bits.
  assign out_o.valid        = (count_q != '0);
  assign out_o.token_kind   = fifo_q[rd_ptr_q].kind;
  assign out_o.token_start  = 32'(fifo_q[rd_ptr_q].start);
  assign out_o.token_length = 32'(fifo_q[rd_ptr_q].length);
  assign out_o.error_kind   = fifo_q[rd_ptr_q].err;
  assign out_o.last_of_run  = fifo_q[rd_ptr_q].last;

  // Checks on the queue and the scanner state.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= RES_CNT_BITS'(RES_DEPTH))
    else $error("result queue overflow");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == RES_CNT_BITS'(RES_PTR_BITS'(wr_ptr_q - rd_ptr_q)) ||
    count_q == RES_CNT_BITS'(RES_DEPTH))
    else $error("queue pointers disagree with fill count");

  a_eot_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.end_of_text |=> pos_q == '0 && !open_q)
    else $error("state not cleared after end of text");

  a_eot_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.end_of_text |-> n_push != 2'd0)
    else $error("end of text produced no token");

endmodule
`default_nettype wire
